### rtl/core/cfpp_pkg.sv
// Shared types and constants for the contour fingertip peak picker.
// No dependencies; every other file in rtl/core imports this package.
package cfpp_pkg;

	localparam int COORD_BITS   = 12;
	localparam int DIST_BITS    = 2 * COORD_BITS + 1;
	localparam int LIMIT_BITS   = 8;
	localparam int MISS_BITS    = LIMIT_BITS + 1;
	localparam int SLOT_BITS    = 3;
	localparam int CFG_BITS     = 12;
	localparam int CFG_IDX_BITS = 2;
	localparam int MAX_TIPS_DEF = 8;

	typedef logic [COORD_BITS-1:0]   coord_t;
	typedef logic [DIST_BITS-1:0]    dist_t;
	typedef logic [LIMIT_BITS-1:0]   limit_t;
	typedef logic [MISS_BITS-1:0]    miss_t;
	typedef logic [SLOT_BITS-1:0]    slot_t;
	typedef logic [CFG_BITS-1:0]     cfg_data_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CENTER_X    = 2'd0,
		CFG_CENTER_Y    = 2'd1,
		CFG_HOLD_LIMIT  = 2'd2,
		CFG_MIN_SPACING = 2'd3
	} cfg_idx_t;

	localparam limit_t HOLD_LIMIT_RST  = 8'd80;
	localparam coord_t MIN_SPACING_RST = 12'd40;

	// One point after the distance stage.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   first;
		dist_t  sq_dist;
	} dist_item_t;

endpackage

### rtl/core/cfpp_dist.sv
// Distance stage: squared distance of a point to the hand center, registered.
// Depends on cfpp_pkg.
module cfpp_dist (
	input  logic                    clk,
	input  logic                    load,
	input  cfpp_pkg::coord_t        point_x,
	input  cfpp_pkg::coord_t        point_y,
	input  logic                    first_point,
	input  cfpp_pkg::coord_t        center_x,
	input  cfpp_pkg::coord_t        center_y,
	output cfpp_pkg::dist_item_t    item_s1
);
	import cfpp_pkg::*;

	coord_t dx, dy;
	logic [2*COORD_BITS-1:0] sqx, sqy;
	dist_t sum;

	assign dx  = (point_x > center_x) ? point_x - center_x : center_x - point_x;
	assign dy  = (point_y > center_y) ? point_y - center_y : center_y - point_y;
	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign sum = {1'b0, sqx} + {1'b0, sqy};

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= '{x: point_x, y: point_y, first: first_point, sq_dist: sum};
		end
	end
endmodule

### rtl/core/cfpp_tip_cell.sv
// One stored tip column; shifts to its neighbor when a new tip enters the row.
// Reports whether the candidate column is too close. Depends on cfpp_pkg.
module cfpp_tip_cell #(
	parameter int INDEX      = 0,
	parameter int TOTAL_BITS = 4
) (
	input  logic                    clk,
	input  logic                    shift_en,
	input  cfpp_pkg::coord_t        col_in,
	output cfpp_pkg::coord_t        col_out,
	input  cfpp_pkg::coord_t        cand_x,
	input  cfpp_pkg::coord_t        min_spacing,
	input  logic [TOTAL_BITS-1:0]   tip_total,
	output logic                    hit
);
	import cfpp_pkg::*;

	localparam logic [TOTAL_BITS-1:0] IDX = TOTAL_BITS'(INDEX);

	coord_t col_q;
	coord_t gap;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign gap     = (cand_x > col_q) ? cand_x - col_q : col_q - cand_x;
	// only cells below the fill level hold a tip of this contour
	assign hit     = (IDX < tip_total) && (gap < min_spacing);
endmodule

### rtl/core/contour_fingertip_peak_picker.sv
// Top level of the contour fingertip peak picker.
// Depends on cfpp_pkg, cfpp_dist and cfpp_tip_cell.

// Contour points arrive one per transfer on the input channel and pass two
// stages: the first registers the squared distance to the configured hand
// center, the second tracks the farthest point, counts points off the peak
// and, when that count passes hold_limit, judges the held peak. An accepted
// fingertip leaves as one transfer on the output channel with its slot index;
// a point that yields no tip produces no transfer. The block takes one point
// per clock; throughput drops only while a finished tip waits on out_stall
// and the distance stage is already full. Stored tip columns live in a row
// of MAX_TIPS cells that shift on each new tip and compare in parallel, so
// the spacing check is combinational. The user must write configuration
// registers only while the block is idle; the block does not enforce it.
module contour_fingertip_peak_picker #(
	parameter int MAX_TIPS = cfpp_pkg::MAX_TIPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [cfpp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  cfpp_pkg::cfg_data_t     cfg_wdata,
	// point input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  cfpp_pkg::coord_t        point_x,
	input  cfpp_pkg::coord_t        point_y,
	input  logic                    first_point,
	// tip output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output cfpp_pkg::coord_t        tip_x,
	output cfpp_pkg::coord_t        tip_y,
	output cfpp_pkg::slot_t         tip_slot
);
	import cfpp_pkg::*;

	localparam int TOTAL_BITS = $clog2(MAX_TIPS + 1);
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = TOTAL_BITS'(MAX_TIPS);

	// configuration registers
	coord_t center_x_q, center_y_q, min_spacing_q;
	limit_t hold_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			hold_limit_q  <= HOLD_LIMIT_RST;
			min_spacing_q <= MIN_SPACING_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:    center_x_q    <= cfg_wdata;
				CFG_CENTER_Y:    center_y_q    <= cfg_wdata;
				CFG_HOLD_LIMIT:  hold_limit_q  <= cfg_wdata[LIMIT_BITS-1:0];
				CFG_MIN_SPACING: min_spacing_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake: stage 2 runs only when the output register is free or
	// draining this cycle, since any point may turn out to be a tip.
	// ---------------------------------------------------------------
	logic       s1_valid_q;
	logic       s2_go;
	logic       in_xfer;
	logic       out_valid_q;
	dist_item_t item_s1;

	assign s2_go    = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s2_go;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (s2_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1: distance
	cfpp_dist u_dist (
		.clk         (clk),
		.load        (in_xfer),
		.point_x     (point_x),
		.point_y     (point_y),
		.first_point (first_point),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.item_s1     (item_s1)
	);

	// ---------------------------------------------------------------
	// Stage 2: peak tracking and tip judgement
	// ---------------------------------------------------------------
	dist_t                 peak_dist_q;
	coord_t                peak_x_q, peak_y_q;
	miss_t                 miss_count_q;
	logic [TOTAL_BITS-1:0] tip_total_q;

	dist_t                 base_dist;
	miss_t                 base_miss, miss_next;
	logic [TOTAL_BITS-1:0] base_total;
	logic                  new_peak, miss, overflow, too_close, emit;
	logic [MAX_TIPS-1:0]   hits;

	// a first point restarts the contour before it is scored
	assign base_dist  = item_s1.first ? '0 : peak_dist_q;
	assign base_miss  = item_s1.first ? '0 : miss_count_q;
	assign base_total = item_s1.first ? '0 : tip_total_q;

	assign new_peak  = item_s1.sq_dist > base_dist;
	// a point that does not set or equal the peak is a miss; the counter
	// deliberately survives a new peak
	assign miss      = !new_peak && (item_s1.sq_dist != base_dist);
	assign miss_next = base_miss + MISS_BITS'(1);
	assign overflow  = miss && (miss_next > {1'b0, hold_limit_q});

	// An overflow never comes with a first point (a first point's distance
	// either sets the peak or equals zero), so the registered peak and tip
	// list are what gets judged here.
	assign too_close = |hits;
	assign emit      = s2_go && overflow && !(center_y_q < peak_y_q) && !too_close
	                   && (tip_total_q < TOTAL_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_dist_q  <= '0;
			peak_x_q     <= '0;
			peak_y_q     <= '0;
			miss_count_q <= '0;
			tip_total_q  <= '0;
		end else if (s2_go) begin
			if (new_peak || item_s1.first) begin
				peak_x_q <= item_s1.x;
				peak_y_q <= item_s1.y;
			end
			if (new_peak) begin
				peak_dist_q <= item_s1.sq_dist;
			end else if (overflow) begin
				peak_dist_q <= '0;
			end else begin
				peak_dist_q <= base_dist;
			end
			if (overflow) begin
				miss_count_q <= '0;
			end else if (miss) begin
				miss_count_q <= miss_next;
			end else begin
				miss_count_q <= base_miss;
			end
			tip_total_q <= emit ? tip_total_q + TOTAL_BITS'(1) : base_total;
		end
	end

	// row of tip cells: newest tip enters cell 0, older ones move up
	coord_t cols [MAX_TIPS];

	for (genvar j = 0; j < MAX_TIPS; j++) begin : g_cell
		cfpp_tip_cell #(
			.INDEX      (j),
			.TOTAL_BITS (TOTAL_BITS)
		) u_cell (
			.clk         (clk),
			.shift_en    (emit),
			.col_in      ((j == 0) ? peak_x_q : cols[(j == 0) ? 0 : j - 1]),
			.col_out     (cols[j]),
			.cand_x      (peak_x_q),
			.min_spacing (min_spacing_q),
			.tip_total   (tip_total_q),
			.hit         (hits[j])
		);
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	coord_t tip_x_q, tip_y_q;
	slot_t  tip_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= emit;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tip_x_q    <= peak_x_q;
			tip_y_q    <= peak_y_q;
			tip_slot_q <= SLOT_BITS'(tip_total_q);
		end
	end

	assign out_valid = out_valid_q;
	assign tip_x     = tip_x_q;
	assign tip_y     = tip_y_q;
	assign tip_slot  = tip_slot_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tip_total_q <= TOTAL_MAX)
		else $error("tip count beyond list size");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || !out_stall))
		else $error("tip overwrote a pending transfer");

	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (tip_total_q == $past(tip_total_q) + TOTAL_BITS'(1)) && out_valid_q)
		else $error("emitted tip not counted or not presented");

endmodule
